// ----- sv/lfna_pkg.sv -----
// Package: shared types, codes and the UTF-8 encoder of the long file name assembler.
`default_nettype none

package lfna_pkg;

   localparam int DEF_MAX_ENTRIES = 20;
   localparam int DEF_MAX_UNITS   = 255;
   localparam int UNITS_PER_FRAG  = 13;
   localparam int CAP_W           = 10;
   localparam logic [CAP_W-1:0] CAP_RESET = 10'd1023;

   localparam logic [15:0] SUR_HI_FIRST = 16'hD800;
   localparam logic [15:0] SUR_HI_LAST  = 16'hDBFF;
   localparam logic [15:0] SUR_LO_FIRST = 16'hDC00;
   localparam logic [15:0] SUR_LO_LAST  = 16'hDFFF;
   localparam logic [20:0] REPL_CP      = 21'h00FFFD;
   localparam logic [20:0] SUPP_BASE    = 21'h010000;

   typedef enum logic [1:0] {
      OP_FEED    = 2'd0,
      OP_TAKE    = 2'd1,
      OP_ABANDON = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      STAT_NAME     = 2'd0,
      STAT_NO_NAME  = 2'd1,
      STAT_OVERFLOW = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      PH_NONE  = 2'd0,
      PH_BUILD = 2'd1,
      PH_DONE  = 2'd2
   } phase_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_FEED,
      S_SUM,
      S_RD,
      S_CV,
      S_END,
      S_STAT
   } seq_type;

   typedef struct packed {
      logic [1:0]  op;
      logic [7:0]  ordinal;
      logic [7:0]  fragment_checksum;
      logic [63:0] units_0_3;
      logic [63:0] units_4_7;
      logic [63:0] units_8_11;
      logic [15:0] unit_12;
      logic [63:0] short_name_lo;
      logic [23:0] short_name_hi;
   } req_payload_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [9:0]  name_length;
      logic [63:0] data_lo;
      logic [63:0] data_hi;
      logic [4:0]  valid_bytes;
      logic        last;
   } rsp_payload_type;

   typedef struct packed {
      logic [3:0][7:0] b;
      logic [2:0]      len;
   } utf8_type;

   function automatic utf8_type utf8_encode(input logic [20:0] cp);
      utf8_type r;
      r = '0;
      if (cp < 21'h80) begin
         r.b[0] = cp[7:0];
         r.len  = 3'd1;
      end else if (cp < 21'h800) begin
         r.b[0] = {3'b110, cp[10:6]};
         r.b[1] = {2'b10, cp[5:0]};
         r.len  = 3'd2;
      end else if (cp < SUPP_BASE) begin
         r.b[0] = {4'b1110, cp[15:12]};
         r.b[1] = {2'b10, cp[11:6]};
         r.b[2] = {2'b10, cp[5:0]};
         r.len  = 3'd3;
      end else begin
         r.b[0] = {5'b11110, cp[20:18]};
         r.b[1] = {2'b10, cp[17:12]};
         r.b[2] = {2'b10, cp[11:6]};
         r.b[3] = {2'b10, cp[5:0]};
         r.len  = 3'd4;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ----- sv/lfna_if.sv -----
// Interfaces: request and response channels of the long file name assembler.
`default_nettype none

interface lfna_req_if;
   logic                     valid;
   logic                     ready;
   lfna_pkg::req_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface lfna_rsp_if;
   logic                     valid;
   logic                     ready;
   lfna_pkg::rsp_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ----- sv/long_file_name_assembler.sv -----
// Top level: VFAT long file name assembler with shared UTF-16 to UTF-8 converter.
//
//   channel   dir   handshake        carries
//   req_ch    in    valid / ready    op, ordinal, checksum, 13 units, short name
//   rsp_ch    out   valid / ready    status, name length, 16-byte beat, last
//   csr_*     in    write enable     output_capacity
//
// A feed item is accepted, then its 13 units are written into the unit
// store, one per cycle through the single write port. An abandon item is
// handled as it is accepted. A take item first forms the checksum of the
// 11-byte short name, then makes two walks over the stored units (length,
// then bytes), each unit read through the store's registered read port,
// with an extra conversion step per lone high surrogate. Stalls on rsp_ch
// hold the walk only when a beat or status must be loaded. Reset is sync,
// clears the run state, sets capacity to CAP_RESET; the store is not cleared.
`default_nettype none

module long_file_name_assembler #(
   parameter int MAX_ENTRIES = lfna_pkg::DEF_MAX_ENTRIES,
   parameter int MAX_UNITS   = lfna_pkg::DEF_MAX_UNITS
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   lfna_req_if.sink                        req_ch,
   lfna_rsp_if.source                      rsp_ch,
   input  wire logic                       csr_wr_en,
   input  wire logic [lfna_pkg::CAP_W-1:0] csr_wr_data
);
   import lfna_pkg::*;

   localparam int DEPTH  = MAX_ENTRIES * UNITS_PER_FRAG;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int IDX_W  = $clog2(DEPTH + 1);
   localparam int ENT_W  = $clog2(MAX_ENTRIES + 1);
   localparam int NB_W   = $clog2(3 * MAX_UNITS + 1);

   // Run tracking
   phase_type          phase_ff, phase_in;
   logic [ENT_W-1:0]   entries_ff, entries_in;
   logic [ENT_W-1:0]   next_ord_ff, next_ord_in;
   logic [7:0]         run_chk_ff, run_chk_in;
   logic [CAP_W-1:0]   cap_ff, cap_in;

   // Sequencer
   seq_type            state_ff, state_in;
   logic [3:0]         cnt_ff, cnt_in;
   logic [ADDR_W-1:0]  wr_addr_ff, wr_addr_in;
   logic [207:0]       units_ff, units_in;
   logic [87:0]        sn_ff, sn_in;
   logic [7:0]         sum_ff, sum_in;
   logic [7:0]         sum_next;
   logic               ok_ff, ok_in;
   logic [IDX_W-1:0]   limit_ff, limit_in;
   logic [IDX_W-1:0]   rd_idx_ff, rd_idx_in;
   logic               pend_ff, pend_in;
   logic [9:0]         hi_ff, hi_in;
   logic               pass2_ff, pass2_in;
   logic [NB_W-1:0]    nbytes_ff, nbytes_in;
   logic [NB_W-1:0]    out_cnt_ff, out_cnt_in;
   logic [4:0]         fill_ff, fill_in;
   logic [19:0][7:0]   buf_ff, buf_in;
   logic [1:0]         stat_ff, stat_in;

   // Response register
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_payload_type    rsp_ff, rsp_in;

   // Unit store
   logic [15:0]        mem [DEPTH];
   logic [15:0]        mem_q_ff;
   logic               mem_we;
   logic               rd_en;

   // Feed decode
   logic [7:0]         frag_num;
   logic [ENT_W-1:0]   frag_n;
   logic               frag_bad;

   // Conversion step
   logic               u_hi, u_lo;
   logic [20:0]        d_cp;
   logic               d_emit, d_adv, d_pend, d_end, d_fail;
   utf8_type           enc;
   logic [4:0]         sum_fill;
   logic               full;
   logic [19:0][7:0]   pack_buf;
   logic [19:0][7:0]   sh_buf;
   logic               out_free;
   logic               step_ok;
   logic               beat_last;

   assign req_ch.ready   = (state_ff == S_IDLE);
   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.payload = rsp_ff;

   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   // Fragment number: ordinal without the run-start flag
   assign frag_num = {req_ch.payload.ordinal[7], 1'b0, req_ch.payload.ordinal[5:0]};
   assign frag_bad = (frag_num == 8'd0) || (32'(frag_num) > MAX_ENTRIES);
   assign frag_n   = ENT_W'(frag_num);

   assign sum_next = {sum_ff[0], sum_ff[7:1]} + sn_ff[7:0];

   assign u_hi = (mem_q_ff >= SUR_HI_FIRST) && (mem_q_ff <= SUR_HI_LAST);
   assign u_lo = (mem_q_ff >= SUR_LO_FIRST) && (mem_q_ff <= SUR_LO_LAST);

   // Decide what the current unit contributes
   always_comb begin
      d_cp   = REPL_CP;
      d_emit = 1'b0;
      d_adv  = 1'b0;
      d_pend = pend_ff;
      d_end  = 1'b0;
      d_fail = 1'b0;
      if (state_ff == S_END) begin
         d_emit = pend_ff;
         d_pend = 1'b0;
      end else if (mem_q_ff == 16'd0) begin
         d_end = 1'b1;
      end else if (32'(rd_idx_ff) == MAX_UNITS) begin
         d_fail = 1'b1;
      end else if (pend_ff) begin
         // lone high surrogate replays the current unit after its U+FFFD
         d_emit = 1'b1;
         d_pend = 1'b0;
         if (u_lo) begin
            d_cp  = SUPP_BASE + {1'b0, hi_ff, mem_q_ff[9:0]};
            d_adv = 1'b1;
         end
      end else if (u_hi) begin
         d_pend = 1'b1;
         d_adv  = 1'b1;
      end else begin
         d_emit = 1'b1;
         d_adv  = 1'b1;
         if (!u_lo) begin
            d_cp = {5'd0, mem_q_ff};
         end
      end
   end

   assign enc = utf8_encode(d_cp);

   // Pack encoded bytes behind the current fill
   always_comb begin
      sum_fill = fill_ff + 5'(enc.len);
      full     = sum_fill[4];
      pack_buf = buf_ff;
      for (int j = 0; j < 20; j++) begin
         for (int k = 0; k < 4; k++) begin
            if ((k < int'(enc.len)) && (j == int'(fill_ff) + k)) begin
               pack_buf[j] = enc.b[k];
            end
         end
      end
      sh_buf      = '0;
      sh_buf[3:0] = pack_buf[19:16];
   end

   assign step_ok   = !pass2_ff || !full || out_free;
   assign beat_last = (32'(out_cnt_ff) + 32'd16) == 32'(nbytes_ff);

   // Sequencer: next state and datapath control
   always_comb begin
      phase_in     = phase_ff;
      entries_in   = entries_ff;
      next_ord_in  = next_ord_ff;
      run_chk_in   = run_chk_ff;
      cap_in       = csr_wr_en ? csr_wr_data : cap_ff;
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      wr_addr_in   = wr_addr_ff;
      units_in     = units_ff;
      sn_in        = sn_ff;
      sum_in       = sum_ff;
      ok_in        = ok_ff;
      limit_in     = limit_ff;
      rd_idx_in    = rd_idx_ff;
      pend_in      = pend_ff;
      hi_in        = hi_ff;
      pass2_in     = pass2_ff;
      nbytes_in    = nbytes_ff;
      out_cnt_in   = out_cnt_ff;
      fill_in      = fill_ff;
      buf_in       = buf_ff;
      stat_in      = stat_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_in       = rsp_ff;
      mem_we       = 1'b0;
      rd_en        = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               case (req_ch.payload.op)
                  OP_FEED: begin
                     if (frag_bad) begin
                        phase_in    = PH_NONE;
                        entries_in  = '0;
                        next_ord_in = '0;
                     end else if (req_ch.payload.ordinal[6] ||
                                  ((phase_ff == PH_BUILD) &&
                                   (frag_n == next_ord_ff) &&
                                   (req_ch.payload.fragment_checksum == run_chk_ff))) begin
                        if (req_ch.payload.ordinal[6]) begin
                           entries_in = frag_n;
                           run_chk_in = req_ch.payload.fragment_checksum;
                        end
                        next_ord_in = frag_n - ENT_W'(1);
                        phase_in    = (frag_n == ENT_W'(1)) ? PH_DONE : PH_BUILD;
                        wr_addr_in  = ADDR_W'((32'(frag_n) - 32'd1) * UNITS_PER_FRAG);
                        units_in    = {req_ch.payload.unit_12, req_ch.payload.units_8_11,
                                       req_ch.payload.units_4_7, req_ch.payload.units_0_3};
                        cnt_in      = '0;
                        state_in    = S_FEED;
                     end else begin
                        phase_in    = PH_NONE;
                        entries_in  = '0;
                        next_ord_in = '0;
                     end
                  end
                  OP_TAKE: begin
                     // take always ends the run; the checksum stays
                     ok_in       = (phase_ff == PH_DONE);
                     limit_in    = IDX_W'(32'(entries_ff) * UNITS_PER_FRAG);
                     phase_in    = PH_NONE;
                     entries_in  = '0;
                     next_ord_in = '0;
                     sn_in       = {req_ch.payload.short_name_hi, req_ch.payload.short_name_lo};
                     sum_in      = '0;
                     cnt_in      = '0;
                     state_in    = S_SUM;
                  end
                  OP_ABANDON: begin
                     phase_in    = PH_NONE;
                     entries_in  = '0;
                     next_ord_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end

         S_FEED: begin
            mem_we     = 1'b1;
            units_in   = units_ff >> 16;
            wr_addr_in = wr_addr_ff + ADDR_W'(1);
            cnt_in     = cnt_ff + 4'd1;
            if (cnt_ff == 4'(UNITS_PER_FRAG - 1)) begin
               state_in = S_IDLE;
            end
         end

         S_SUM: begin
            sum_in = sum_next;
            sn_in  = sn_ff >> 8;
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == 4'd10) begin
               if (ok_ff && (sum_next == run_chk_ff)) begin
                  rd_idx_in = '0;
                  pend_in   = 1'b0;
                  pass2_in  = 1'b0;
                  nbytes_in = '0;
                  state_in  = S_RD;
               end else begin
                  stat_in  = STAT_NO_NAME;
                  state_in = S_STAT;
               end
            end
         end

         S_RD: begin
            if (rd_idx_ff == limit_ff) begin
               state_in = S_END;
            end else begin
               rd_en    = 1'b1;
               state_in = S_CV;
            end
         end

         S_CV, S_END: begin
            if ((state_ff == S_CV) && d_end) begin
               state_in = S_END;
            end else if ((state_ff == S_CV) && d_fail) begin
               stat_in  = STAT_NO_NAME;
               state_in = S_STAT;
            end else if (d_emit || (state_ff == S_CV)) begin
               if (!d_emit || step_ok) begin
                  if (d_emit) begin
                     if (!pass2_ff) begin
                        nbytes_in = nbytes_ff + NB_W'(enc.len);
                     end else if (!full) begin
                        buf_in  = pack_buf;
                        fill_in = sum_fill;
                     end else begin
                        rsp_valid_in        = 1'b1;
                        rsp_in.status       = STAT_NAME;
                        rsp_in.name_length  = CAP_W'(nbytes_ff);
                        rsp_in.data_lo      = pack_buf[7:0];
                        rsp_in.data_hi      = pack_buf[15:8];
                        rsp_in.valid_bytes  = 5'd16;
                        rsp_in.last         = beat_last;
                        buf_in              = sh_buf;
                        fill_in             = sum_fill - 5'd16;
                        out_cnt_in          = out_cnt_ff + NB_W'(16);
                     end
                  end
                  pend_in = d_pend;
                  if (d_pend && !pend_ff) begin
                     hi_in = mem_q_ff[9:0];
                  end
                  if (d_adv) begin
                     rd_idx_in = rd_idx_ff + IDX_W'(1);
                     state_in  = S_RD;
                  end
               end
            end else if (!pass2_ff) begin
               // length walk done: check for an empty name and capacity
               if (rd_idx_ff == '0) begin
                  stat_in  = STAT_NO_NAME;
                  state_in = S_STAT;
               end else if (32'(nbytes_ff) > 32'(cap_ff)) begin
                  stat_in  = STAT_OVERFLOW;
                  state_in = S_STAT;
               end else begin
                  pass2_in   = 1'b1;
                  rd_idx_in  = '0;
                  pend_in    = 1'b0;
                  fill_in    = '0;
                  out_cnt_in = '0;
                  buf_in     = '0;
                  state_in   = S_RD;
               end
            end else if (fill_ff == 5'd0) begin
               state_in = S_IDLE;
            end else if (out_free) begin
               // flush the partial final beat
               rsp_valid_in        = 1'b1;
               rsp_in.status       = STAT_NAME;
               rsp_in.name_length  = CAP_W'(nbytes_ff);
               rsp_in.data_lo      = buf_ff[7:0];
               rsp_in.data_hi      = buf_ff[15:8];
               rsp_in.valid_bytes  = fill_ff;
               rsp_in.last         = 1'b1;
               state_in            = S_IDLE;
            end
         end

         S_STAT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '0;
               rsp_in.status = stat_ff;
               rsp_in.last   = 1'b1;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_NONE;
         entries_ff   <= '0;
         next_ord_ff  <= '0;
         run_chk_ff   <= '0;
         cap_ff       <= CAP_RESET;
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         entries_ff   <= entries_in;
         next_ord_ff  <= next_ord_in;
         run_chk_ff   <= run_chk_in;
         cap_ff       <= cap_in;
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      cnt_ff     <= cnt_in;
      wr_addr_ff <= wr_addr_in;
      units_ff   <= units_in;
      sn_ff      <= sn_in;
      sum_ff     <= sum_in;
      ok_ff      <= ok_in;
      limit_ff   <= limit_in;
      rd_idx_ff  <= rd_idx_in;
      pend_ff    <= pend_in;
      hi_ff      <= hi_in;
      pass2_ff   <= pass2_in;
      nbytes_ff  <= nbytes_in;
      out_cnt_ff <= out_cnt_in;
      fill_ff    <= fill_in;
      buf_ff     <= buf_in;
      stat_ff    <= stat_in;
      rsp_ff     <= rsp_in;
   end

   // Unit store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_addr_ff] <= units_ff[15:0];
      end
      if (rd_en) begin
         mem_q_ff <= mem[rd_idx_ff[ADDR_W-1:0]];
      end
   end

endmodule

`default_nettype wire
